// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/shss_pkg.sv -----
// Shared types, constants and tables of the half-step move sequencer.
package shss_pkg;

    // Default width of the angle field, in 1/64 degree units
    localparam int ANGLE_BITS_DEF = 20;

    localparam int SPEED_W   = 4;
    localparam int COIL_W    = 4;
    localparam int PHASE_W   = 3;
    localparam int SEQ_W     = 15;
    localparam int HOLD_W    = 4;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // Register map, word index taken from paddr[2]
    localparam logic REG_SPEED_RPM = 1'b0;
    localparam logic [SPEED_W-1:0] SPEED_RESET = 4'd1;

    // Item codes
    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_START = 1'b1;

    // Sequence count: floor(angle / 45), saturated at 2^15 - 1.
    // Below the saturation limit the angle fits 21 bits, and a
    // 22-bit reciprocal with a 27-bit shift divides exactly.
    localparam int           SEQ_IN_BITS = 21;
    localparam logic [20:0]  SEQ_SAT_LIMIT = 21'd1474560;  // 45 * 32768
    localparam int           RECIP_SHIFT = 27;
    localparam logic [21:0]  RECIP_45 = 22'd2982617;        // ceil(2^27 / 45)
    localparam int           PROD_W = 43;

    localparam logic [PHASE_W-1:0] PHASE_FIRST = 3'd0;
    localparam logic [PHASE_W-1:0] PHASE_LAST  = 3'd7;

    typedef struct packed {
        logic             zero;
        logic [SEQ_W-1:0] count;
    } shss_count_t;

    typedef struct packed {
        logic [COIL_W-1:0] coil;
        logic              busy;
        logic              done;
    } shss_result_t;

    // Half-step coil patterns, bit0 = IN1 .. bit3 = IN4
    function automatic logic [COIL_W-1:0] half_pattern(input logic [PHASE_W-1:0] idx);
        logic [COIL_W-1:0] p;
        case (idx)
            3'd0:    p = 4'h1;
            3'd1:    p = 4'h3;
            3'd2:    p = 4'h2;
            3'd3:    p = 4'h6;
            3'd4:    p = 4'h4;
            3'd5:    p = 4'hC;
            3'd6:    p = 4'h8;
            default: p = 4'h9;
        endcase
        return p;
    endfunction

    // Ticks per half step: 14 / rpm, zero speed as 1, never below one tick
    function automatic logic [HOLD_W-1:0] hold_length(input logic [SPEED_W-1:0] rpm);
        logic [HOLD_W-1:0] h;
        case (rpm)
            4'd0, 4'd1:                  h = 4'd14;
            4'd2:                        h = 4'd7;
            4'd3:                        h = 4'd4;
            4'd4:                        h = 4'd3;
            4'd5, 4'd6, 4'd7:            h = 4'd2;
            default:                     h = 4'd1;
        endcase
        return h;
    endfunction

endpackage

// ----- rtl/shss_seq_count.sv -----
// Sequence count from the start angle: floor(angle / 45) with saturation.
module shss_seq_count #(
    parameter int ANGLE_BITS = shss_pkg::ANGLE_BITS_DEF
) (
    input  logic [ANGLE_BITS-1:0] angle_q6,
    output shss_pkg::shss_count_t cnt
);
    import shss_pkg::*;

    localparam int EXT_W = (ANGLE_BITS > SEQ_IN_BITS) ? ANGLE_BITS : SEQ_IN_BITS;

    logic [EXT_W-1:0]       angle_ext;
    logic                   sat;
    logic [PROD_W-1:0]      prod;
    logic [SEQ_W-1:0]       quot;

    // Widen so the limit compare works at any angle width
    assign angle_ext = EXT_W'(angle_q6);
    assign sat       = angle_ext >= EXT_W'(SEQ_SAT_LIMIT);

    // Multiply by the reciprocal of 45; exact below the saturation limit
    assign prod = PROD_W'(angle_ext[SEQ_IN_BITS-1:0]) * PROD_W'(RECIP_45);
    assign quot = prod[RECIP_SHIFT +: SEQ_W];

    assign cnt.count = sat ? {SEQ_W{1'b1}} : quot;
    assign cnt.zero  = !sat && (quot == '0);

endmodule

// ----- rtl/shss_core.sv -----
// Move state of the sequencer and its per-item update.
module shss_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          commit,
    input  logic                          mode,
    input  logic                          anticlockwise,
    input  shss_pkg::shss_count_t         cnt,
    input  logic [shss_pkg::SPEED_W-1:0]  speed_rpm,
    output shss_pkg::shss_result_t        result
);
    import shss_pkg::*;

    logic               moving_reg,  moving_next;
    logic               acw_reg,     acw_next;
    logic [PHASE_W-1:0] phase_reg,   phase_next;
    logic [SEQ_W-1:0]   seq_reg,     seq_next;
    logic [HOLD_W-1:0]  hold_reg,    hold_next;
    logic [COIL_W-1:0]  coil_reg,    coil_next;
    logic               done;

    logic [HOLD_W-1:0]  hold_dec;
    logic               last_in_seq;
    logic [SEQ_W-1:0]   seq_dec;
    logic [PHASE_W-1:0] phase_step;
    logic [PHASE_W-1:0] phase_start;

    assign hold_dec    = (hold_reg != '0) ? hold_reg - 1'b1 : hold_reg;
    assign last_in_seq = acw_reg ? (phase_reg == PHASE_LAST) : (phase_reg == PHASE_FIRST);
    assign seq_dec     = (seq_reg != '0) ? seq_reg - 1'b1 : seq_reg;
    assign phase_step  = acw_reg ? phase_reg + 1'b1 : phase_reg - 1'b1;
    assign phase_start = anticlockwise ? PHASE_FIRST : PHASE_LAST;

    // Next state for the transaction in the input stage
    always_comb
    begin
        moving_next = moving_reg;
        acw_next    = acw_reg;
        phase_next  = phase_reg;
        seq_next    = seq_reg;
        hold_next   = hold_reg;
        coil_next   = coil_reg;
        done        = 1'b0;
        if (mode == MODE_START) begin
            if (!moving_reg) begin
                if (cnt.zero) begin
                    done = 1'b1;
                end
                else begin
                    moving_next = 1'b1;
                    acw_next    = anticlockwise;
                    seq_next    = cnt.count;
                    phase_next  = phase_start;
                    coil_next   = half_pattern(phase_start);
                    hold_next   = hold_length(speed_rpm);
                end
            end
        end
        else if (moving_reg) begin
            hold_next = hold_dec;
            if (hold_dec == '0) begin
                if (last_in_seq) begin
                    seq_next = seq_dec;
                end
                if (last_in_seq && (seq_dec == '0)) begin
                    moving_next = 1'b0;
                    done        = 1'b1;
                end
                else begin
                    phase_next = phase_step;
                    coil_next  = half_pattern(phase_step);
                    hold_next  = hold_length(speed_rpm);
                end
            end
        end
    end

    assign result.coil = coil_next;
    assign result.busy = moving_next;
    assign result.done = done;

    // Advance state when the transaction moves to the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            moving_reg <= 1'b0;
            acw_reg    <= 1'b0;
            phase_reg  <= '0;
            seq_reg    <= '0;
            hold_reg   <= '0;
            coil_reg   <= '0;
        end
        else if (commit) begin
            moving_reg <= moving_next;
            acw_reg    <= acw_next;
            phase_reg  <= phase_next;
            seq_reg    <= seq_next;
            hold_reg   <= hold_next;
            coil_reg   <= coil_next;
        end
    end

endmodule

// ----- rtl/stepper_half_step_move_sequencer.sv -----
// Top level of the half-step stepper move sequencer.
// Each input transaction is a millisecond tick (mode 0) or a move start (mode 1);
// every transaction gives one result with the coil drive, busy and done. The
// block takes one transaction per clock while in_stall is low: it passes through
// an input register, the state update and sequence-count multiply, and an output
// register, so a result is presented once it moves into the output register and is
// taken at an edge when the output is not stalled.
// in_stall rises only while both registers hold a transaction and out_stall is high.
// speed_rpm sits at byte address 0 of the APB port and sets the hold of
// 14 / speed_rpm ticks per half step; write it only while no transaction is in
// flight. During a move a new speed applies from the next half step on.
module stepper_half_step_move_sequencer #(
    parameter int ANGLE_BITS = shss_pkg::ANGLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          mode,
    input  logic [ANGLE_BITS-1:0]         angle_q6,
    input  logic                          anticlockwise,
    // output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [shss_pkg::COIL_W-1:0]   coil_pattern,
    output logic                          busy_res,
    output logic                          done_res,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [shss_pkg::PADDR_W-1:0]  paddr,
    input  logic [shss_pkg::PDATA_W-1:0]  pwdata,
    output logic [shss_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import shss_pkg::*;

    logic [SPEED_W-1:0]     speed_reg;
    logic                   s1_vld_reg;
    logic                   s1_mode_reg;
    logic [ANGLE_BITS-1:0]  s1_angle_reg;
    logic                   s1_acw_reg;
    logic                   out_vld_reg;
    shss_result_t           out_reg;
    logic                   out_free;
    logic                   advance;
    logic                   cfg_wr;
    shss_count_t            cnt;
    shss_result_t           result;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SPEED_RPM);
    assign prdata = (paddr[2] == REG_SPEED_RPM) ? PDATA_W'(speed_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            speed_reg <= SPEED_RESET;
        end
        else if (cfg_wr) begin
            speed_reg <= pwdata[SPEED_W-1:0];
        end
    end

    // Handshake between the two register stages
    assign out_free = !out_vld_reg || !out_stall;
    assign advance  = s1_vld_reg && out_free;
    assign in_stall = s1_vld_reg && !out_free;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_vld_reg <= 1'b0;
        end
        else if (!in_stall) begin
            s1_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid) begin
            s1_mode_reg  <= mode;
            s1_angle_reg <= angle_q6;
            s1_acw_reg   <= anticlockwise;
        end
    end

    shss_seq_count #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_seq_count (
        .angle_q6 (s1_angle_reg),
        .cnt      (cnt)
    );

    shss_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .commit        (advance),
        .mode          (s1_mode_reg),
        .anticlockwise (s1_acw_reg),
        .cnt           (cnt),
        .speed_rpm     (speed_reg),
        .result        (result)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_vld_reg <= 1'b0;
        end
        else if (out_free) begin
            out_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign out_valid    = out_vld_reg;
    assign coil_pattern = out_reg.coil;
    assign busy_res     = out_reg.busy;
    assign done_res     = out_reg.done;

endmodule

// ----- rtl/shss_checker.sv -----
// Port-level checks of the sequencer and their binding to the top level.
`include "assert_macros.svh"

module shss_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [shss_pkg::COIL_W-1:0]   coil_pattern,
    input logic                          busy_res,
    input logic                          done_res
);

    logic [shss_pkg::COIL_W+1:0] out_fields;
    logic                        pattern_ok;

    // Gather the result fields and flag a legal half-step pattern
    assign out_fields = {coil_pattern, busy_res, done_res};
    assign pattern_ok = (coil_pattern == 4'h1) || (coil_pattern == 4'h3) ||
                        (coil_pattern == 4'h2) || (coil_pattern == 4'h6) ||
                        (coil_pattern == 4'h4) || (coil_pattern == 4'hC) ||
                        (coil_pattern == 4'h8) || (coil_pattern == 4'h9);

    // A finished move is never still busy
    `ASSERT_NEVER(a_done_not_busy, clk, rst_n, out_valid && busy_res && done_res)

    // While moving, the coils show one of the half-step patterns
    `ASSERT_IMPLIES(a_busy_pattern, clk, rst_n, out_valid && busy_res, pattern_ok)

    // Input backs up only behind a waiting result
    `ASSERT_IMPLIES(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

    // Hold a stalled result
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_fields))

endmodule

bind stepper_half_step_move_sequencer shss_checker u_shss_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .coil_pattern (coil_pattern),
    .busy_res     (busy_res),
    .done_res     (done_res)
);

// ----- dv/testbench.sv -----
// Self-checking testbench of the half-step stepper move sequencer.
`timescale 1ns / 100ps

module testbench;

    import shss_pkg::*;

    localparam int ANGLE_BITS = ANGLE_BITS_DEF;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_PER_PHASE = 50;

    // Half-step coil patterns, index to IN4..IN1
    localparam logic [COIL_W-1:0] COIL_STEPS [8] = '{
        4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
    };

    typedef struct packed {
        logic                  md;
        logic [ANGLE_BITS-1:0] ang;
        logic                  ccw;
    } cmd_t;

    typedef struct {
        logic               moving;
        logic               ccw;
        logic [PHASE_W-1:0] phase;
        logic [SEQ_W-1:0]   seq_left;
        logic [HOLD_W-1:0]  hold_left;
        logic [COIL_W-1:0]  coil;
    } motion_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  mode;
    logic [ANGLE_BITS-1:0] angle_q6;
    logic                  anticlockwise;
    logic                  out_valid;
    logic                  out_stall;
    logic [COIL_W-1:0]     coil_pattern;
    logic                  busy_res;
    logic                  done_res;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [PDATA_W-1:0]    pwdata;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    // Planned commands, the command on the pins, and the expected drive results
    cmd_t         cmd_q[$];
    cmd_t         cur_cmd;
    bit           holding;
    shss_result_t drive_q[$];

    // Motion state: one copy follows generation, one follows accepted transactions
    motion_t           plan_motion;
    motion_t           live_motion;
    logic [SPEED_W-1:0] plan_rpm;
    logic [SPEED_W-1:0] live_rpm;

    int unsigned send_idle_pct;
    int unsigned stall_pct;
    int          errors;
    int          cycles;

    stepper_half_step_move_sequencer #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .angle_q6     (angle_q6),
        .anticlockwise(anticlockwise),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .coil_pattern (coil_pattern),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance the motion state by one command and return the drive it leaves
    function automatic shss_result_t step_motion(inout motion_t m,
                                                 input logic [SPEED_W-1:0] rpm,
                                                 input cmd_t c);
        shss_result_t      r;
        logic              finish;
        logic              wrap;
        logic [31:0]       n;
        logic [HOLD_W-1:0] hold;
        finish = 1'b0;
        hold = (rpm == 0) ? HOLD_W'(14) : HOLD_W'(14 / rpm);
        if (hold == 0)
            hold = HOLD_W'(1);
        if (c.md == MODE_START) begin
            if (!m.moving) begin
                n = 32'(c.ang) / 32'd45;
                if (n > 32'd32767)
                    n = 32'd32767;
                if (n == 0) begin
                    finish = 1'b1;
                end
                else begin
                    m.moving = 1'b1;
                    m.ccw = c.ccw;
                    m.seq_left = SEQ_W'(n);
                    m.phase = c.ccw ? 3'd0 : 3'd7;
                    m.coil = COIL_STEPS[m.phase];
                    m.hold_left = hold;
                end
            end
        end
        else if (m.moving) begin
            if (m.hold_left != 0)
                m.hold_left = m.hold_left - 1'b1;
            if (m.hold_left == 0) begin
                wrap = m.ccw ? (m.phase == 3'd7) : (m.phase == 3'd0);
                if (wrap) begin
                    if (m.seq_left != 0)
                        m.seq_left = m.seq_left - 1'b1;
                    if (m.seq_left == 0)
                        finish = 1'b1;
                end
                if (finish) begin
                    m.moving = 1'b0;
                end
                else begin
                    m.phase = m.ccw ? m.phase + 3'd1 : m.phase - 3'd1;
                    m.coil = COIL_STEPS[m.phase];
                    m.hold_left = hold;
                end
            end
        end
        r.coil = m.coil;
        r.busy = m.moving;
        r.done = finish;
        return r;
    endfunction

    // Drive the input channel and the receiver stall
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (!holding) begin
                if (cmd_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cur_cmd = cmd_q.pop_front();
                    holding = 1'b1;
                    in_valid <= 1'b1;
                    mode <= cur_cmd.md;
                    angle_q6 <= cur_cmd.ang;
                    anticlockwise <= cur_cmd.ccw;
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Predict on each accepted command, check each accepted result
    always @(posedge clk)
    begin
        shss_result_t want;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                drive_q.push_back(step_motion(live_motion, live_rpm, cur_cmd));
                holding = 1'b0;
            end
            if (out_valid && !out_stall) begin
                if (drive_q.size() == 0) begin
                    $error("unexpected result transaction: coil_pattern %0h", coil_pattern);
                    errors++;
                end
                else begin
                    want = drive_q.pop_front();
                    if (coil_pattern !== want.coil) begin
                        $error("coil_pattern expected %0h actual %0h", want.coil, coil_pattern);
                        errors++;
                    end
                    if (busy_res !== want.busy) begin
                        $error("busy_res expected %0b actual %0b", want.busy, busy_res);
                        errors++;
                    end
                    if (done_res !== want.done) begin
                        $error("done_res expected %0b actual %0b", want.done, done_res);
                        errors++;
                    end
                end
            end
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Plan one command against the generation copy of the motion state
    task automatic queue_cmd(input logic md, input logic [ANGLE_BITS-1:0] ang,
                             input logic ccw);
        cmd_t         c;
        shss_result_t unused;
        c.md = md;
        c.ang = ang;
        c.ccw = ccw;
        unused = step_motion(plan_motion, plan_rpm, c);
        cmd_q.push_back(c);
    endtask

    task automatic queue_tick();
        queue_cmd(MODE_TICK, ANGLE_BITS'($urandom()), 1'($urandom()));
    endtask

    // Tick until the planned move has finished
    task automatic run_out_move();
        while (plan_motion.moving)
            queue_tick();
    endtask

    // Mostly ticks through short moves, with starts that land while busy
    task automatic run_random(input int count);
        int unsigned r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (plan_motion.moving) begin
                if (r < 88)
                    queue_tick();
                else
                    queue_cmd(MODE_START, ANGLE_BITS'($urandom()), 1'($urandom()));
            end
            else if (r < 20) begin
                queue_tick();
            end
            else if (r < 40) begin
                queue_cmd(MODE_START, ANGLE_BITS'($urandom_range(0, 44)), 1'($urandom()));
            end
            else begin
                queue_cmd(MODE_START, ANGLE_BITS'($urandom_range(45, 134)), 1'($urandom()));
            end
        end
        run_out_move();
    endtask

    // Wait until every command is sent and every result has come back
    task automatic settle();
        do
            @(negedge clk);
        while (cmd_q.size() != 0 || holding || drive_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_speed(input logic [SPEED_W-1:0] v);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({REG_SPEED_RPM, 2'b00});
        pwdata <= PDATA_W'(v);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        plan_rpm = v;
        live_rpm = v;
    endtask

    task automatic set_idle(input int sel);
        case (sel)
            1:       begin send_idle_pct = 71; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 71; end
            3:       begin send_idle_pct = 28; stall_pct = 28; end
            default: begin send_idle_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    initial
    begin
        logic [SPEED_W-1:0] speed_plan [6];
        speed_plan = '{4'd15, 4'd0, 4'd2, 4'd13, 4'd7, 4'd1};

        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = MODE_TICK;
        angle_q6 = '0;
        anticlockwise = 1'b0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        holding = 1'b0;
        errors = 0;
        cycles = 0;
        plan_motion = '{default: '0};
        live_motion = '{default: '0};
        plan_rpm = SPEED_RESET;
        live_rpm = SPEED_RESET;
        set_idle(0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: idle ticks, moves too short to step, one and two sequences,
        // starts while busy, all at the reset speed
        queue_cmd(MODE_TICK, '1, 1'b1);
        queue_cmd(MODE_START, '0, 1'b0);
        queue_cmd(MODE_START, ANGLE_BITS'(44), 1'b1);
        queue_cmd(MODE_TICK, '0, 1'b0);
        queue_cmd(MODE_START, ANGLE_BITS'(45), 1'b0);
        queue_cmd(MODE_START, '1, 1'b1);
        queue_cmd(MODE_START, '0, 1'b0);
        run_out_move();
        queue_cmd(MODE_START, ANGLE_BITS'(90), 1'b1);
        repeat (5) queue_tick();
        queue_cmd(MODE_START, ANGLE_BITS'(45), 1'b0);
        run_out_move();
        queue_cmd(MODE_TICK, '0, 1'b1);
        settle();

        // Several sequences at the fastest stepping rate
        write_speed(4'd13);
        queue_cmd(MODE_START, ANGLE_BITS'(400), 1'b0);
        run_out_move();
        settle();

        // Random phases across speeds and idling patterns
        for (int p = 0; p < 6; p++) begin
            write_speed(speed_plan[p]);
            set_idle(p % 4);
            run_random(RANDOM_PER_PHASE);
            settle();
        end

        repeat (8) @(negedge clk);
        if (errors == 0 && drive_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
